@@ hw/rtl/utr_pkg.sv @@
// ----------------------------------------------------------------------------
// utr_pkg
// Shared types, codes and reset values of the serial transceiver with rx ring.
// ----------------------------------------------------------------------------
package utr_pkg;

  localparam int FIFO_DEPTH_DEF  = 256;
  localparam int TIMER_WIDTH_DEF = 24;

  // configuration port
  localparam int CFG_DW = 24;
  localparam int CFG_IW = 3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_BIT_PERIOD  = 3'd0,
    CFG_DATA_BITS   = 3'd1,
    CFG_PARITY_MODE = 3'd2,
    CFG_STOP_BITS   = 3'd3,
    CFG_SAMPLE_LEAD = 3'd4,
    CFG_FIFO_SIZE   = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_SEND = 2'd1,
    REQ_READ = 2'd2,
    REQ_PEEK = 2'd3
  } req_type_t;

  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_EVEN = 2'd1;
  localparam logic [1:0] PAR_ODD  = 2'd2;

  localparam logic [1:0] STOP_TWO = 2'd2;

  localparam logic [3:0] DATA_BITS_MIN = 4'd5;
  localparam logic [3:0] DATA_BITS_MAX = 4'd8;

  // register reset values
  localparam logic [23:0] BIT_PERIOD_RST  = 24'd8333;
  localparam logic [3:0]  DATA_BITS_RST   = 4'd8;
  localparam logic [1:0]  PARITY_RST      = PAR_NONE;
  localparam logic [1:0]  STOP_BITS_RST   = 2'd1;
  localparam logic [15:0] SAMPLE_LEAD_RST = 16'd0;
  localparam int          FIFO_SIZE_RST   = 256;

endpackage

@@ hw/rtl/utr_req_if.sv @@
// ----------------------------------------------------------------------------
// utr_req_if
// Request channel: one clock tick of line activity plus an optional request.
// ----------------------------------------------------------------------------
interface utr_req_if;

  logic              valid;
  logic              ready;
  utr_pkg::req_type_t req_type;
  logic [7:0]        tx_byte;
  logic              rx_level;

  modport source (output valid, output req_type, output tx_byte, output rx_level,
                  input ready);
  modport sink   (input valid, input req_type, input tx_byte, input rx_level,
                  output ready);

endinterface

@@ hw/rtl/utr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// utr_rsp_if
// Result channel: line and ring status after one tick.
// ----------------------------------------------------------------------------
interface utr_rsp_if;

  logic       valid;
  logic       ready;
  logic       tx_level;
  logic       tx_busy;
  logic       tx_accepted;
  logic [7:0] rx_data;
  logic       rx_empty;
  logic [7:0] rx_available;
  logic       rx_stored;

  modport source (output valid, output tx_level, output tx_busy, output tx_accepted,
                  output rx_data, output rx_empty, output rx_available,
                  output rx_stored, input ready);
  modport sink   (input valid, input tx_level, input tx_busy, input tx_accepted,
                  input rx_data, input rx_empty, input rx_available,
                  input rx_stored, output ready);

endinterface

@@ hw/rtl/uart_transceiver_with_rx_ring_core.sv @@
// ----------------------------------------------------------------------------
// uart_transceiver_with_rx_ring_core
// Serial transceiver stepped one tick per request, with a receive ring buffer.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  req      | in  | valid/ready   | req_type, tx_byte, rx_level
//  rsp      | out | valid/ready   | tx_level, tx_busy, tx_accepted, rx_data,
//           |     |               | rx_empty, rx_available, rx_stored
//  cfg_wr_* | in  | enable only   | cfg_wr_index, cfg_wr_data
//
//  One request per cycle while rsp does not stall and the remainder unit is
//  idle; each result passes the input register, then the result register.
//  A ring head register is prefetched every cycle so reads skip the memory wait.
//  A fifo_size write starts a bit-serial remainder unit that holds req.ready low
//  until the successor pointers have been recomputed.
//  Reset (rst, synchronous) clears control state; ring contents stay undefined.
//  A stalled rsp holds one result and one request; then req.ready drops.
// ----------------------------------------------------------------------------
module uart_transceiver_with_rx_ring_core #(
  parameter int FIFO_DEPTH  = utr_pkg::FIFO_DEPTH_DEF,
  parameter int TIMER_WIDTH = utr_pkg::TIMER_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [utr_pkg::CFG_IW-1:0] cfg_wr_index,
  input  logic [utr_pkg::CFG_DW-1:0] cfg_wr_data,
  utr_req_if.sink                    req,
  utr_rsp_if.source                  rsp
);

  localparam int TW  = TIMER_WIDTH;
  localparam int RXW = TW + 1;
  localparam int LW  = (RXW > 16) ? RXW : 16;
  localparam int PW  = $clog2(FIFO_DEPTH);
  localparam int SW  = $clog2(FIFO_DEPTH + 1);
  localparam int AW  = (SW + 1 > 8) ? SW + 1 : 8;
  localparam int ZW  = (SW > 9) ? SW : 9;
  localparam int NB  = PW + 1;
  localparam int CNW = $clog2(NB + 1);
  localparam int MW  = 2 * TW + 1;

  // x / 3 == (x * DIV3_M) >> (TW + 2) for any TW-bit x
  localparam logic [TW:0] DIV3_M = (TW + 1)'(((65'd1 << (TW + 2)) + 65'd2) / 65'd3);

  localparam logic [TW-1:0] PER_RAW   = TW'(utr_pkg::BIT_PERIOD_RST);
  localparam logic [TW-1:0] PER_RST   = (PER_RAW == '0) ? TW'(1) : PER_RAW;
  localparam logic [TW-1:0] THIRD_RST = TW'(PER_RST / 3);
  localparam int            FSZ_RST_I = (utr_pkg::FIFO_SIZE_RST > FIFO_DEPTH) ?
                                        FIFO_DEPTH : utr_pkg::FIFO_SIZE_RST;
  localparam logic [SW-1:0] FSZ_RST   = SW'(FSZ_RST_I);
  localparam logic [PW-1:0] SUCC_RST  = PW'(1 % FSZ_RST_I);

  // --------------------------------------------------------------------------
  // configuration registers (stored in effective form)
  // --------------------------------------------------------------------------
  logic [TW-1:0] per;
  logic [TW-1:0] third;
  logic [3:0]    dbits;
  logic          par_en;
  logic          par_odd;
  logic          two_stop;
  logic [15:0]   lead;
  logic [SW-1:0] fsz;

  logic [TW-1:0] wr_per;
  logic [TW-1:0] wr_per_eff;
  logic [MW-1:0] wr_prod;
  logic [3:0]    wr_db;
  logic [ZW-1:0] wr_z;
  logic [SW-1:0] wr_fsz;
  logic          wr_fsz_hit;

  always_comb begin
    wr_per     = TW'(cfg_wr_data);
    wr_per_eff = (wr_per == '0) ? TW'(1) : wr_per;
    wr_prod    = MW'(wr_per_eff) * MW'(DIV3_M);
    if (cfg_wr_data[3:0] < utr_pkg::DATA_BITS_MIN) begin
      wr_db = utr_pkg::DATA_BITS_MIN;
    end else if (cfg_wr_data[3:0] > utr_pkg::DATA_BITS_MAX) begin
      wr_db = utr_pkg::DATA_BITS_MAX;
    end else begin
      wr_db = cfg_wr_data[3:0];
    end
    wr_z = ZW'(cfg_wr_data[8:0]);
    if (wr_z == '0) begin
      wr_fsz = SW'(1);
    end else if (wr_z > ZW'(FIFO_DEPTH)) begin
      wr_fsz = SW'(FIFO_DEPTH);
    end else begin
      wr_fsz = SW'(wr_z);
    end
    wr_fsz_hit = cfg_wr_en && (cfg_wr_index == utr_pkg::CFG_FIFO_SIZE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      per      <= PER_RST;
      third    <= THIRD_RST;
      dbits    <= utr_pkg::DATA_BITS_RST;
      par_en   <= (utr_pkg::PARITY_RST == utr_pkg::PAR_EVEN) ||
                  (utr_pkg::PARITY_RST == utr_pkg::PAR_ODD);
      par_odd  <= (utr_pkg::PARITY_RST == utr_pkg::PAR_ODD);
      two_stop <= (utr_pkg::STOP_BITS_RST == utr_pkg::STOP_TWO);
      lead     <= utr_pkg::SAMPLE_LEAD_RST;
      fsz      <= FSZ_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_wr_index)
        utr_pkg::CFG_BIT_PERIOD: begin
          per   <= wr_per_eff;
          third <= TW'(wr_prod >> (TW + 2));
        end
        utr_pkg::CFG_DATA_BITS: begin
          dbits <= wr_db;
        end
        utr_pkg::CFG_PARITY_MODE: begin
          par_en  <= (cfg_wr_data[1:0] == utr_pkg::PAR_EVEN) ||
                     (cfg_wr_data[1:0] == utr_pkg::PAR_ODD);
          par_odd <= (cfg_wr_data[1:0] == utr_pkg::PAR_ODD);
        end
        utr_pkg::CFG_STOP_BITS: begin
          two_stop <= (cfg_wr_data[1:0] == utr_pkg::STOP_TWO);
        end
        utr_pkg::CFG_SAMPLE_LEAD: begin
          lead <= cfg_wr_data[15:0];
        end
        utr_pkg::CFG_FIFO_SIZE: begin
          fsz <= wr_fsz;
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake: input register and result register
  // --------------------------------------------------------------------------
  logic               s1_valid;
  utr_pkg::req_type_t s1_req_type;
  logic [7:0]         s1_tx_byte;
  logic               s1_rx_level;
  logic               o_valid;
  logic               out_free;
  logic               step_en;
  logic               mod_busy;
  logic               in_xfer;

  assign out_free  = !o_valid || rsp.ready;
  assign step_en   = s1_valid && out_free;
  assign req.ready = !mod_busy && (!s1_valid || out_free);
  assign in_xfer   = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (step_en) begin
        s1_valid <= 1'b0;
      end
      if (step_en) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_type <= req.req_type;
      s1_tx_byte  <= req.tx_byte;
      s1_rx_level <= req.rx_level;
    end
  end

  // --------------------------------------------------------------------------
  // tick state
  // --------------------------------------------------------------------------
  logic [TW-1:0]  tx_timer;
  logic [10:0]    tx_frame;
  logic [3:0]     tx_bits_left;
  logic           tx_line;
  logic [RXW-1:0] rx_timer;
  logic           rx_active;
  logic [3:0]     rx_bit_index;
  logic [7:0]     rx_shift;
  logic           rx_prev_level;
  logic [PW-1:0]  write_pos;
  logic [PW-1:0]  read_pos;
  logic [PW-1:0]  wp_succ;
  logic [PW-1:0]  rp_succ;

  logic [TW-1:0]  tx_timer_next;
  logic [10:0]    tx_frame_next;
  logic [3:0]     tx_bits_left_next;
  logic           tx_line_next;
  logic [RXW-1:0] rx_timer_next;
  logic           rx_active_next;
  logic [3:0]     rx_bit_index_next;
  logic [7:0]     rx_shift_next;
  logic [PW-1:0]  write_pos_next;
  logic [PW-1:0]  read_pos_next;
  logic [PW-1:0]  wp_succ_next;
  logic [PW-1:0]  rp_succ_next;

  // ring head prefetch
  logic [7:0]     mem_rdata;
  logic           byp_hit;
  logic [7:0]     byp_data;
  logic [7:0]     head;

  // frame build
  logic [10:0]    frame_new;
  logic [3:0]     bits_new;
  logic           par_bit;
  logic [7:0]     dmask;

  // scratch
  logic [TW:0]    t_inc;
  logic [RXW-1:0] t_dec;
  logic [3:0]     rx_last;
  logic [LW-1:0]  base_x;
  logic [LW-1:0]  lead_x;
  logic [RXW-1:0] first_delay;
  logic [SW-1:0]  wps_inc;
  logic [SW-1:0]  rps_inc;
  logic [AW-1:0]  wpx;
  logic [AW-1:0]  rpx;
  logic [AW-1:0]  avail;

  logic           acc;
  logic           stored;
  logic           empty;
  logic [7:0]     rdata;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      dmask[i] = (4'(i) < dbits);
    end
    par_bit = (^(s1_tx_byte & dmask)) ^ par_odd;
    frame_new[0] = 1'b0;
    for (int i = 1; i < 11; i++) begin
      if (i <= 8 && 4'(i) <= dbits) begin
        frame_new[i] = s1_tx_byte[(i - 1) % 8];
      end else if (par_en && 4'(i) == dbits + 4'd1) begin
        frame_new[i] = par_bit;
      end else begin
        frame_new[i] = 1'b1;
      end
    end
    bits_new = 4'd2 + dbits + {3'd0, par_en} + {3'd0, two_stop};

    // transmitter
    tx_timer_next     = tx_timer;
    tx_frame_next     = tx_frame;
    tx_bits_left_next = tx_bits_left;
    tx_line_next      = tx_line;
    acc               = 1'b0;
    t_inc             = (TW + 1)'(tx_timer) + (TW + 1)'(1);
    if (tx_bits_left != 4'd0) begin
      if (t_inc >= (TW + 1)'(per)) begin
        tx_timer_next     = '0;
        tx_frame_next     = {1'b1, tx_frame[10:1]};
        tx_bits_left_next = tx_bits_left - 4'd1;
      end else begin
        tx_timer_next = TW'(t_inc);
      end
      tx_line_next = (tx_bits_left_next != 4'd0) ? tx_frame_next[0] : 1'b1;
    end else if (s1_req_type == utr_pkg::REQ_SEND) begin
      tx_frame_next     = frame_new;
      tx_bits_left_next = bits_new;
      tx_timer_next     = '0;
      tx_line_next      = 1'b0;
      acc               = 1'b1;
    end

    // receiver
    rx_timer_next     = rx_timer;
    rx_active_next    = rx_active;
    rx_bit_index_next = rx_bit_index;
    rx_shift_next     = rx_shift;
    stored            = 1'b0;
    t_dec             = (rx_timer != '0) ? rx_timer - RXW'(1) : rx_timer;
    rx_last           = dbits + {3'd0, par_en} + {3'd0, two_stop};
    base_x            = LW'(per) + LW'(third);
    lead_x            = LW'(lead);
    first_delay       = (base_x > lead_x) ? RXW'(base_x - lead_x) : RXW'(1);
    if (rx_active) begin
      rx_timer_next = t_dec;
      if (t_dec == '0) begin
        for (int i = 0; i < 8; i++) begin
          if (rx_bit_index == 4'(i) && 4'(i) < dbits && s1_rx_level) begin
            rx_shift_next[i] = 1'b1;
          end
        end
        if (rx_bit_index >= rx_last) begin
          stored            = 1'b1;
          rx_active_next    = 1'b0;
          rx_bit_index_next = 4'd0;
        end else begin
          rx_bit_index_next = rx_bit_index + 4'd1;
          rx_timer_next     = RXW'(per);
        end
      end
    end else if (rx_prev_level && !s1_rx_level) begin
      rx_active_next    = 1'b1;
      rx_timer_next     = first_delay;
      rx_bit_index_next = 4'd0;
      rx_shift_next     = 8'd0;
    end

    // ring pointers; the successor registers are kept below the ring size
    wps_inc        = SW'(wp_succ) + SW'(1);
    rps_inc        = SW'(rp_succ) + SW'(1);
    write_pos_next = stored ? wp_succ : write_pos;
    wp_succ_next   = wp_succ;
    if (stored) begin
      wp_succ_next = (wps_inc == fsz) ? '0 : PW'(wps_inc);
    end
    read_pos_next = read_pos;
    rp_succ_next  = rp_succ;
    empty         = 1'b0;
    rdata         = 8'd0;
    head          = byp_hit ? byp_data : mem_rdata;
    if (s1_req_type == utr_pkg::REQ_READ || s1_req_type == utr_pkg::REQ_PEEK) begin
      if (write_pos_next == read_pos) begin
        empty = 1'b1;
      end else begin
        // a byte stored this tick into an empty ring is the head
        rdata = (stored && write_pos == read_pos) ? rx_shift_next : head;
        if (s1_req_type == utr_pkg::REQ_READ) begin
          read_pos_next = rp_succ;
          rp_succ_next  = (rps_inc == fsz) ? '0 : PW'(rps_inc);
        end
      end
    end
    wpx   = AW'(write_pos_next);
    rpx   = AW'(read_pos_next);
    avail = (wpx >= rpx) ? wpx - rpx : wpx + AW'(fsz) - rpx;
  end

  // --------------------------------------------------------------------------
  // successor recompute after a ring size change: (pos + 1) mod size,
  // one quotient bit per cycle for both pointers
  // --------------------------------------------------------------------------
  logic [NB-1:0]  num_w;
  logic [NB-1:0]  num_r;
  logic [SW-1:0]  rem_w;
  logic [SW-1:0]  rem_r;
  logic [CNW-1:0] mod_cnt;
  logic [SW:0]    rw2;
  logic [SW:0]    rr2;
  logic [SW-1:0]  rem_w_next;
  logic [SW-1:0]  rem_r_next;

  always_comb begin
    rw2        = {rem_w, num_w[NB-1]};
    rr2        = {rem_r, num_r[NB-1]};
    rem_w_next = (rw2 >= (SW + 1)'(fsz)) ? SW'(rw2 - (SW + 1)'(fsz)) : SW'(rw2);
    rem_r_next = (rr2 >= (SW + 1)'(fsz)) ? SW'(rr2 - (SW + 1)'(fsz)) : SW'(rr2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_timer      <= '0;
      tx_frame      <= '1;
      tx_bits_left  <= 4'd0;
      tx_line       <= 1'b1;
      rx_timer      <= '0;
      rx_active     <= 1'b0;
      rx_bit_index  <= 4'd0;
      rx_shift      <= 8'd0;
      rx_prev_level <= 1'b1;
      write_pos     <= '0;
      read_pos      <= '0;
      wp_succ       <= SUCC_RST;
      rp_succ       <= SUCC_RST;
      mod_busy      <= 1'b0;
      mod_cnt       <= '0;
    end else begin
      if (step_en) begin
        tx_timer      <= tx_timer_next;
        tx_frame      <= tx_frame_next;
        tx_bits_left  <= tx_bits_left_next;
        tx_line       <= tx_line_next;
        rx_timer      <= rx_timer_next;
        rx_active     <= rx_active_next;
        rx_bit_index  <= rx_bit_index_next;
        rx_shift      <= rx_shift_next;
        rx_prev_level <= s1_rx_level;
        write_pos     <= write_pos_next;
        read_pos      <= read_pos_next;
        wp_succ       <= wp_succ_next;
        rp_succ       <= rp_succ_next;
      end
      if (wr_fsz_hit) begin
        mod_busy <= 1'b1;
        mod_cnt  <= CNW'(NB);
      end else if (mod_busy) begin
        mod_cnt <= mod_cnt - CNW'(1);
        if (mod_cnt == CNW'(1)) begin
          mod_busy <= 1'b0;
          wp_succ  <= PW'(rem_w_next);
          rp_succ  <= PW'(rem_r_next);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fsz_hit) begin
      num_w <= NB'(write_pos) + NB'(1);
      num_r <= NB'(read_pos) + NB'(1);
      rem_w <= '0;
      rem_r <= '0;
    end else if (mod_busy) begin
      num_w <= {num_w[NB-2:0], 1'b0};
      num_r <= {num_r[NB-2:0], 1'b0};
      rem_w <= rem_w_next;
      rem_r <= rem_r_next;
    end
  end

  // --------------------------------------------------------------------------
  // ring memory; the read port always fetches the head for the next tick
  // --------------------------------------------------------------------------
  logic [7:0]    ring_mem [FIFO_DEPTH];
  logic          mem_we;
  logic [PW-1:0] mem_raddr;

  assign mem_we    = step_en && stored;
  assign mem_raddr = step_en ? read_pos_next : read_pos;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[write_pos] <= rx_shift_next;
    end
    mem_rdata <= ring_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= mem_we && (write_pos == mem_raddr);
    end
    byp_data <= rx_shift_next;
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (step_en) begin
      rsp.tx_level     <= tx_line_next;
      rsp.tx_busy      <= (tx_bits_left_next != 4'd0);
      rsp.tx_accepted  <= acc;
      rsp.rx_data      <= rdata;
      rsp.rx_empty     <= empty;
      rsp.rx_available <= avail[7:0];
      rsp.rx_stored    <= stored;
    end
  end

  assign rsp.valid = o_valid;

endmodule

@@ hw/rtl/utr_checker.sv @@
// ----------------------------------------------------------------------------
// utr_checker
// Port-level checks on the transceiver core, attached by bind.
// ----------------------------------------------------------------------------
module utr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       tx_level,
  input logic       tx_busy,
  input logic       tx_accepted,
  input logic [7:0] rx_data,
  input logic       rx_empty
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({tx_level, tx_busy, tx_accepted, rx_data, rx_empty}))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_empty |-> rx_data == 8'd0)
    else $error("empty ring read returned nonzero data");

  // an accepted send starts the frame with the start bit
  a_send_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_accepted |-> tx_busy && !tx_level)
    else $error("accepted send without start bit");

  a_idle_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_busy |-> tx_level)
    else $error("transmit line low while idle");

endmodule

bind uart_transceiver_with_rx_ring_core utr_checker u_utr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .tx_level    (rsp.tx_level),
  .tx_busy     (rsp.tx_busy),
  .tx_accepted (rsp.tx_accepted),
  .rx_data     (rsp.rx_data),
  .rx_empty    (rsp.rx_empty)
);
